// ----- rtl/core/psd_pkg.sv -----
// Package for the piezo strike detector: field widths, register indexes,
// reset values and the struct types shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int TIME_W        = 32;
    localparam int SAMPLE_W      = 12;
    localparam int THRESH_W      = 12;
    localparam int DUR_W         = 16;
    localparam int SAMPLE_FIELDS = 4;
    localparam int HIT_PAD_W     = 2;
    localparam int FLAGS_W       = 4;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_TDATA_W    = TIME_W + SAMPLE_FIELDS * SAMPLE_W;
    localparam int OUT_TDATA_W   = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CROSSTALK = 8'd3;

    // Reset values
    localparam logic [THRESH_W-1:0] RST_THRESHOLD = 12'd500;
    localparam logic [DUR_W-1:0]    RST_DEBOUNCE  = 16'd50;
    localparam logic [DUR_W-1:0]    RST_HOLD      = 16'd20;
    localparam logic [DUR_W-1:0]    RST_CROSSTALK = 16'd15;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [DUR_W-1:0]    debounce;
        logic [DUR_W-1:0]    hold;
        logic [DUR_W-1:0]    crosstalk;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]                      now_ms;
    } t_scan;

    typedef struct packed {
        logic                 hit;
        logic [HIT_PAD_W-1:0] hit_pad;
        logic [FLAGS_W-1:0]   triggered_flags;
    } t_result;

endpackage

// ----- rtl/core/psd_cfg_regs.sv -----
// Configuration register file of the piezo strike detector.
// Depends on psd_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module psd_cfg_regs
    import psd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_THRESHOLD: n_cfg.threshold = i_cfg_data[THRESH_W-1:0];
                CFG_IDX_DEBOUNCE:  n_cfg.debounce  = i_cfg_data[DUR_W-1:0];
                CFG_IDX_HOLD:      n_cfg.hold      = i_cfg_data[DUR_W-1:0];
                CFG_IDX_CROSSTALK: n_cfg.crosstalk = i_cfg_data[DUR_W-1:0];
                default:           n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.debounce  <= RST_DEBOUNCE;
            r_cfg.hold      <= RST_HOLD;
            r_cfg.crosstalk <= RST_CROSSTALK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/psd_scan_eval.sv -----
// Per-scan evaluation: strike tests, crosstalk mask, lowest-index priority, hold release.
// Depends on psd_pkg for t_cfg, t_scan, t_result and field widths.
`timescale 1ns / 1ps

module psd_scan_eval
    import psd_pkg::*;
#(
    parameter int PAD_COUNT = 4
) (
    input  t_cfg                              i_cfg,
    input  t_scan                             i_scan,
    input  logic [PAD_COUNT-1:0][TIME_W-1:0]  i_strike_time,
    input  logic [PAD_COUNT-1:0]              i_triggered,
    input  logic [TIME_W-1:0]                 i_last_hit,
    output logic [PAD_COUNT-1:0][TIME_W-1:0]  o_strike_time,
    output logic [PAD_COUNT-1:0]              o_triggered,
    output logic [TIME_W-1:0]                 o_last_hit,
    output t_result                           o_result
);

    logic [TIME_W-1:0]    since_any;
    logic                 masked;
    logic [PAD_COUNT-1:0] cand;
    logic [PAD_COUNT-1:0] fire;
    logic [FLAGS_W-1:0]   fire_lo;
    logic [FLAGS_W-1:0]   trig_lo;

    assign since_any = i_scan.now_ms - i_last_hit;
    assign masked    = since_any < {{(TIME_W-DUR_W){1'b0}}, i_cfg.crosstalk};

    for (genvar i = 0; i < PAD_COUNT; i++) begin : g_pad
        logic [TIME_W-1:0] elapsed;
        assign elapsed = i_scan.now_ms - i_strike_time[i];

        if (i < SAMPLE_FIELDS) begin : g_sampled
            assign cand[i] = (i_scan.sample[i] > i_cfg.threshold) && !i_triggered[i]
                          && (elapsed > {{(TIME_W-DUR_W){1'b0}}, i_cfg.debounce});
        end else begin : g_unsampled
            // no sample field: sample reads as zero and never exceeds the threshold
            assign cand[i] = 1'b0;
        end

        if (i == 0) begin : g_first
            assign fire[i] = !masked && cand[i];
        end else begin : g_rest
            assign fire[i] = !masked && cand[i] && (cand[i-1:0] == '0);
        end

        // A pad that fires now stays triggered and cannot release this scan
        assign o_triggered[i] = fire[i] ||
            (i_triggered[i] && !(elapsed > {{(TIME_W-DUR_W){1'b0}}, i_cfg.hold}));
        assign o_strike_time[i] = fire[i] ? i_scan.now_ms : i_strike_time[i];
    end

    for (genvar k = 0; k < FLAGS_W; k++) begin : g_low
        if (k < PAD_COUNT) begin : g_present
            assign fire_lo[k] = fire[k];
            assign trig_lo[k] = o_triggered[k];
        end else begin : g_absent
            assign fire_lo[k] = 1'b0;
            assign trig_lo[k] = 1'b0;
        end
    end

    assign o_last_hit = (|fire) ? i_scan.now_ms : i_last_hit;

    // fire is one-hot or zero, so the index is a plain OR encode
    assign o_result.hit             = |fire;
    assign o_result.hit_pad         = {fire_lo[2] | fire_lo[3], fire_lo[1] | fire_lo[3]};
    assign o_result.triggered_flags = trig_lo;

endmodule

// ----- rtl/core/piezo_strike_detector.sv -----
// An accepted scan beat passes the input register, then the result register, before
// it is valid on the master side. Throughput: one scan per cycle, sustained while the
// master side accepts results; the per-pad state is registered with each scan that
// moves on, so the next scan sees it. A stalled master side holds both registers and
// backs up the input. Reset (synchronous, active low): strike times, triggered flags
// and last-hit time clear, registers load defaults.
`timescale 1ns / 1ps

module piezo_strike_detector
    import psd_pkg::*;
#(
    parameter int PAD_COUNT = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Scan input: tdata = now_ms[31:0], sample_0, sample_1, sample_2, sample_3
    // (12 bits each, from bit 32 up)
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result: tdata = hit_pad[1:0], triggered_flags[5:2], zero fill [7:6]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser = hit
    output logic                   m_axis_tuser,
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    w_cfg;

    // Input stage
    logic    r_in_valid;
    t_scan   r_scan;

    // Per-pad state
    logic [PAD_COUNT-1:0][TIME_W-1:0] r_strike_time;
    logic [PAD_COUNT-1:0]             r_triggered;
    logic [TIME_W-1:0]                r_last_hit;

    logic [PAD_COUNT-1:0][TIME_W-1:0] n_strike_time;
    logic [PAD_COUNT-1:0]             n_triggered;
    logic [TIME_W-1:0]                n_last_hit;
    t_result                          w_result;

    // Result stage
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    accept;

    psd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    psd_scan_eval #(
        .PAD_COUNT (PAD_COUNT)
    ) u_eval (
        .i_cfg         (w_cfg),
        .i_scan        (r_scan),
        .i_strike_time (r_strike_time),
        .i_triggered   (r_triggered),
        .i_last_hit    (r_last_hit),
        .o_strike_time (n_strike_time),
        .o_triggered   (n_triggered),
        .o_last_hit    (n_last_hit),
        .o_result      (w_result)
    );

    // Move the held scan into the result register whenever that slot frees up;
    // the pad state commits in the same cycle, so the next scan sees it.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: hold while stalled, load on each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scan <= t_scan'(s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike_time <= '0;
            r_triggered   <= '0;
            r_last_hit    <= '0;
        end else if (advance) begin
            r_strike_time <= n_strike_time;
            r_triggered   <= n_triggered;
            r_last_hit    <= n_last_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.hit;
    assign m_axis_tdata  = {{(OUT_TDATA_W-HIT_PAD_W-FLAGS_W){1'b0}},
                            r_out.triggered_flags, r_out.hit_pad};

    // A scan that moves on always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated scan did not reach the result register");

    // A reported strike comes with at least one triggered pad
    a_hit_has_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> (r_out.triggered_flags != '0))
        else $error("strike reported with no triggered pad");

    // No strike reports pad zero
    a_idle_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |-> (r_out.hit_pad == '0))
        else $error("pad index set without a strike");

    // Last-hit time moves only on a strike
    a_last_hit_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && w_result.hit) |=> $stable(r_last_hit))
        else $error("last hit time changed without a strike");

endmodule

// ----- dv/piezo_strike_detector_tb.sv -----
// Self-checking testbench for piezo_strike_detector: scan beats with random idling
// on both stream sides, register writes between phases, and a scoreboard with its own model.
// Depends on psd_pkg and the piezo_strike_detector RTL.
`timescale 1ns / 1ps

module piezo_strike_detector_tb;
    import psd_pkg::*;

    localparam int NUM_PADS = SAMPLE_FIELDS;
    // Register indexes outside the map; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 8'hFF;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX       = '1;

    // Scoreboard: tracks pad state, predicts one result per scan, checks results in order
    class strike_scoreboard;
        logic [THRESH_W-1:0] thresh;
        logic [DUR_W-1:0]    debounce_lim;
        logic [DUR_W-1:0]    hold_ms;
        logic [DUR_W-1:0]    xtalk_ms;
        logic [TIME_W-1:0]   strike_at [NUM_PADS];
        logic                pad_latched [NUM_PADS];
        logic [TIME_W-1:0]   last_strike_any;
        t_result             expected_results [$];
        int                  fail_count;
        int                  results_seen;
        int                  hits_seen;

        function new();
            thresh          = RST_THRESHOLD;
            debounce_lim    = RST_DEBOUNCE;
            hold_ms         = RST_HOLD;
            xtalk_ms        = RST_CROSSTALK;
            last_strike_any = '0;
            for (int p = 0; p < NUM_PADS; p++) begin
                strike_at[p]   = '0;
                pad_latched[p] = 1'b0;
            end
            fail_count   = 0;
            results_seen = 0;
            hits_seen    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_THRESHOLD: thresh       = data[THRESH_W-1:0];
                CFG_IDX_DEBOUNCE:  debounce_lim = data[DUR_W-1:0];
                CFG_IDX_HOLD:      hold_ms      = data[DUR_W-1:0];
                CFG_IDX_CROSSTALK: xtalk_ms     = data[DUR_W-1:0];
                default: ;
            endcase
        endfunction

        // Visit pads in index order; the first strike masks the rest of the scan
        function void note_scan(t_scan s);
            logic [TIME_W-1:0] since;
            logic              masked;
            t_result           r;
            r      = '0;
            since  = s.now_ms - last_strike_any;
            masked = (since < TIME_W'(xtalk_ms));
            for (int p = 0; p < NUM_PADS; p++) begin
                since = s.now_ms - strike_at[p];
                if (!masked && s.sample[p] > thresh && !pad_latched[p] &&
                    since > TIME_W'(debounce_lim)) begin
                    pad_latched[p]  = 1'b1;
                    strike_at[p]    = s.now_ms;
                    last_strike_any = s.now_ms;
                    masked          = 1'b1;
                    r.hit           = 1'b1;
                    r.hit_pad       = HIT_PAD_W'(p);
                end
                since = s.now_ms - strike_at[p];
                if (pad_latched[p] && since > TIME_W'(hold_ms))
                    pad_latched[p] = 1'b0;
                r.triggered_flags[p] = pad_latched[p];
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(t_result got, logic [1:0] fill);
            t_result want;
            results_seen++;
            if (got.hit)
                hits_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat hit=%0b pad=%0d flags=%b",
                         $time, got.hit, got.hit_pad, got.triggered_flags);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, got.hit);
                fail_count++;
            end
            if (got.hit_pad !== want.hit_pad) begin
                $display("%0t: hit_pad mismatch: expected %0d, actual %0d",
                         $time, want.hit_pad, got.hit_pad);
                fail_count++;
            end
            if (got.triggered_flags !== want.triggered_flags) begin
                $display("%0t: triggered_flags mismatch: expected %b, actual %b",
                         $time, want.triggered_flags, got.triggered_flags);
                fail_count++;
            end
            if (fill !== 2'b00) begin
                $display("%0t: tdata fill mismatch: expected 00, actual %b", $time, fill);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_CADENCE} t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    strike_scoreboard board = new();

    logic [TIME_W-1:0] cursor;
    int  burst_left;
    bit  gapless;
    int  scans_sent;
    int  cfg_writes;
    int  settings_run;
    bit  long_stall_done;

    piezo_strike_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Result monitor: tdata = hit_pad[1:0], triggered_flags[5:2], fill[7:6]; tuser = hit
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[5:2]},
                               m_axis_tdata[7:6]);
    end

    // Receiver: runs of random stall patterns, plus one long hold-off to back up the block
    initial begin
        t_rx_mode mode;
        int       run_left;
        int       stall_left;
        int       tick;
        logic     rdy;
        mode            = RX_OPEN;
        run_left        = 0;
        stall_left      = 0;
        tick            = 0;
        long_stall_done = 1'b0;
        m_axis_tready   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!long_stall_done && board.results_seen >= 500) begin
                long_stall_done = 1'b1;
                stall_left      = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    run_left = $urandom_range(20, 150);
                end
                run_left--;
                tick++;
                case (mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = ((tick % 3) != 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // Offer one scan beat; entered and left at a falling edge
    task automatic push_scan(input t_scan s);
        int gap;
        if (burst_left == 0) begin
            gap        = gapless ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_scan(s);
        scans_sent++;
        @(negedge i_clk);
    endtask

    task automatic scan4(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] a,
                         input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] c,
                         input logic [SAMPLE_W-1:0] d);
        t_scan s;
        s.now_ms    = now;
        s.sample[0] = a;
        s.sample[1] = b;
        s.sample[2] = c;
        s.sample[3] = d;
        push_scan(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait for the pipe to drain before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mix of quiet, hot, full-range and edge samples around the current threshold
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int                  r;
        logic [SAMPLE_W-1:0] t;
        t = board.thresh;
        r = $urandom_range(0, 9);
        if (r <= 3)
            return SAMPLE_W'($urandom_range(0, t));
        if (r <= 6)
            return (t == SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_W'($urandom_range(t + 1, SAMPLE_MAX));
        if (r == 7)
            return SAMPLE_W'($urandom);
        if (r == 8)
            return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
        return (t == SAMPLE_MAX) ? t : t + SAMPLE_W'($urandom_range(0, 1));
    endfunction

    // Time mostly advances in steps scaled to the durations; sometimes jump or wrap
    task automatic random_scans(input int count, input int span);
        t_scan s;
        int    pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                cursor += $urandom_range(0, span);
            else if (pick < 88)
                cursor += $urandom_range(span, 8 * span);
            else if (pick < 94)
                cursor = $urandom;
            else
                cursor = '1 - TIME_W'($urandom_range(0, span));
            s.now_ms = cursor;
            for (int p = 0; p < NUM_PADS; p++)
                s.sample[p] = pick_sample();
            push_scan(s);
        end
    endtask

    task automatic run_phase(input logic [THRESH_W-1:0] thr, input logic [DUR_W-1:0] deb,
                             input logic [DUR_W-1:0] hold, input logic [DUR_W-1:0] xt,
                             input int span, input int count, input bit no_gaps);
        settle();
        // Upper data bits of the threshold write are junk and must be ignored
        write_reg(CFG_IDX_THRESHOLD, {4'($urandom), thr});
        write_reg(CFG_IDX_DEBOUNCE, deb);
        write_reg(CFG_IDX_HOLD, hold);
        write_reg(CFG_IDX_CROSSTALK, xt);
        gapless = no_gaps;
        settings_run++;
        random_scans(count, span);
    endtask

    initial begin
        int waited;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        cursor        = '0;
        burst_left    = 0;
        gapless       = 1'b0;
        scans_sent    = 0;
        cfg_writes    = 0;
        settings_run  = 1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed scans under reset defaults
        scan4(32'd0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);   // too soon after reset
        scan4(32'd50, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);  // debounce not exceeded
        scan4(32'd51, 12'd500, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);     // pad 0 at threshold only
        scan4(32'd51, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);  // crosstalk mask
        scan4(32'd66, 12'd501, 12'd0, 12'd0, 12'd0);                    // mask just expired
        scan4(32'd71, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);  // hold boundary
        scan4(32'd72, 12'd0, 12'd0, 12'd0, 12'd0);                      // hold released
        scan4(32'hFFFF_FFF0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        scan4(32'h0000_0005, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX); // time wrap
        scan4(32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0, 12'd0);
        scan4(32'h0000_0000, 12'd0, 12'd0, 12'd0, SAMPLE_MAX);
        scan4(32'hAAAA_AAAA, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        scan4(32'h5555_5555, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        scan4(32'h5555_5600, 12'd0, 12'd0, SAMPLE_MAX, SAMPLE_MAX);     // lowest pad wins
        cursor = 32'h5555_5600;
        random_scans(250, 20);

        // Writes to unmapped indexes must leave every register alone
        settle();
        write_reg(CFG_IDX_SPARE_LO, 16'h0000);
        write_reg(CFG_IDX_SPARE_HI, 16'hFFFF);
        random_scans(40, 20);

        run_phase(12'd0, 16'd0, 16'd0, 16'd0, 3, 250, 1'b1);
        run_phase(12'hFFF, 16'd10, 16'd10, 16'd10, 10, 100, 1'b0);
        run_phase(12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20000, 250, 1'b0);
        run_phase(12'd1000, 16'd30, 16'd100, 16'd5, 40, 300, 1'b1);
        run_phase(12'($urandom), 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                  16'($urandom_range(0, 100)), 60, 360, 1'b0);
        run_phase(12'd100, 16'd5, 16'd2, 16'd0, 8, 300, 1'b0);

        // Drain, then keep watching for stray beats before the final check
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (board.pending() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending());
            board.fail_count++;
        end

        $display("Run covered %0d scans across %0d register settings (%0d config writes).",
                 scans_sent, settings_run, cfg_writes);
        $display("Checked %0d results with %0d strikes; long output hold-off %s.",
                 board.results_seen, board.hits_seen, long_stall_done ? "done" : "not reached");
        if (board.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run
    initial begin
        #(12 * 600000);
        $display("Timeout: results or handshakes stopped advancing");
        $display("Test completed with failures");
        $finish;
    end

endmodule
